// ----- sv/vpa_pkg.sv -----
// Package for the variable partition allocator: sizes, codes and shared types.
// Used by the controller, the datapath and the top level.
package vpa_pkg;

  localparam int unsigned MaxFree = 16;
  localparam int unsigned MaxProc = 16;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned FIdxW   = $clog2(MaxFree);
  localparam int unsigned PIdxW   = $clog2(MaxProc);
  localparam int unsigned FCntW   = $clog2(MaxFree + 1);
  localparam int unsigned PCntW   = $clog2(MaxProc + 1);

  localparam logic [1:0] CfgPolicy = 2'd0;
  localparam logic [1:0] CfgMemSize = 2'd1;
  localparam logic [1:0] CfgMinSlice = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StNoPid   = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_ACHK, S_ASCAN, S_ACARVE, S_COMP, S_FSRCH, S_FPOS, S_FMERGE,
    S_FSHIFT, S_FUSED, S_DROP, S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start_alloc;
    logic       start_free;
    logic       scan_step;
    logic       carve;
    logic       comp_step;
    logic       comp_done;
    logic       srch_step;
    logic       pos_step;
    logic       merge;
    logic       fshift_step;
    logic       used_step;
    logic       drop_step;
    logic       set_status;
    logic [1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic proc_full;
    logic size_zero;
    logic scan_done;
    logic found;
    logic total_ok;
    logic comp_last;
    logic srch_done;
    logic srch_hit;
    logic pos_done;
    logic need_insert;
    logic free_full;
    logic drop_needed;
    logic fshift_done;
    logic used_done;
    logic drop_done;
  } sts_t;

endpackage

// ----- sv/vpa_ctrl.sv -----
// Controller state machine for the allocator.
// Depends on vpa_pkg; drives the datapath with cmd_t and reads sts_t.
module vpa_ctrl import vpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_op_i,
  output logic req_ready_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   res_q, res_d;

  assign req_ready_o = (state_q == S_IDLE) && !res_q;
  assign res_valid_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_valid_i && req_ready_o) state_d = req_op_i ? S_FSRCH : S_ACHK;
      S_ACHK:   state_d = (sts_i.proc_full || sts_i.size_zero) ? S_OUT : S_ASCAN;
      S_ASCAN:  if (sts_i.scan_done) begin
        if (sts_i.found) state_d = S_ACARVE;
        else if (sts_i.total_ok) state_d = S_COMP;
        else state_d = S_OUT;
      end
      S_COMP:   if (sts_i.comp_last) state_d = S_ACARVE;
      S_ACARVE: state_d = sts_i.drop_needed ? S_DROP : S_OUT;
      S_DROP:   if (sts_i.drop_done) state_d = S_OUT;
      S_FSRCH:  if (sts_i.srch_done) state_d = sts_i.srch_hit ? S_FPOS : S_OUT;
      S_FPOS:   if (sts_i.pos_done) state_d = S_FMERGE;
      S_FMERGE: begin
        if (sts_i.free_full) state_d = S_OUT;
        else if (sts_i.need_insert) state_d = S_FSHIFT;
        else state_d = S_FUSED;
      end
      S_FSHIFT: if (sts_i.fshift_done) state_d = S_FUSED;
      S_FUSED:  if (sts_i.used_done) state_d = sts_i.drop_needed ? S_DROP : S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d = res_q;
    if (res_q && res_ready_i) res_d = 1'b0;
    if (state_q == S_OUT) res_d = 1'b1;
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.start_alloc = req_valid_i && req_ready_o && !req_op_i;
        cmd_o.start_free  = req_valid_i && req_ready_o && req_op_i;
      end
      S_ACHK: begin
        cmd_o.set_status = sts_i.proc_full || sts_i.size_zero;
        cmd_o.status     = sts_i.proc_full ? StFull : StNoSpace;
      end
      S_ASCAN: begin
        cmd_o.scan_step  = !sts_i.scan_done;
        cmd_o.set_status = sts_i.scan_done && !sts_i.found && !sts_i.total_ok;
        cmd_o.status     = StNoSpace;
      end
      S_COMP: begin
        cmd_o.comp_step = !sts_i.comp_last;
        cmd_o.comp_done = sts_i.comp_last;
      end
      S_ACARVE: cmd_o.carve = 1'b1;
      S_DROP:   cmd_o.drop_step = 1'b1;
      S_FSRCH: begin
        cmd_o.srch_step  = !sts_i.srch_done;
        cmd_o.set_status = sts_i.srch_done && !sts_i.srch_hit;
        cmd_o.status     = StNoPid;
      end
      S_FPOS: cmd_o.pos_step = !sts_i.pos_done;
      S_FMERGE: begin
        cmd_o.merge      = !sts_i.free_full;
        cmd_o.set_status = sts_i.free_full;
        cmd_o.status     = StFull;
      end
      S_FSHIFT: cmd_o.fshift_step = 1'b1;
      S_FUSED:  cmd_o.used_step = 1'b1;
      S_OUT:    ;
      default:  ;
    endcase
  end

endmodule

// ----- sv/vpa_dp.sv -----
// Datapath of the allocator: free and allocation tables, scan and shift logic.
// Depends on vpa_pkg; steered by the controller through cmd_t.
module vpa_dp import vpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  input  logic [15:0]      req_size_i,
  input  logic [15:0]      req_pid_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic [1:0]       status_o,
  output logic [15:0]      pid_o,
  output logic [AddrW-1:0] start_o,
  output logic [15:0]      size_o
);

  logic [1:0]       policy_q;
  logic [15:0]      minsl_q;
  logic [AddrW-1:0] fs_q [MaxFree];
  logic [15:0]      fl_q [MaxFree];
  logic [15:0]      up_q [MaxProc];
  logic [AddrW-1:0] us_q [MaxProc];
  logic [15:0]      ul_q [MaxProc];
  logic [FCntW-1:0] fcnt_q;
  logic [PCntW-1:0] ucnt_q;
  logic [15:0]      ftot_q, npid_q, size_q;
  logic [FCntW-1:0] fi_q;   // free table cursor
  logic [PCntW-1:0] ui_q;   // allocation table cursor
  logic [FCntW-1:0] sel_q;
  logic             found_q, srch_done_q, pos_done_q;
  logic             mp_q, mn_q, drop_q;
  logic [AddrW-1:0] addr_q;
  logic [1:0]       st_q;
  logic [15:0]      pid_q, got_q;
  logic [AddrW-1:0] start_q;
  logic [FCntW-1:0] dropi_q;  // free entry to remove by shifting down

  wire [FIdxW-1:0] fi  = fi_q[FIdxW-1:0];
  wire [FIdxW-1:0] sel = sel_q[FIdxW-1:0];
  wire [PIdxW-1:0] ui  = ui_q[PIdxW-1:0];
  wire             f_in = (fi_q < fcnt_q);
  wire             u_in = (ui_q < ucnt_q);
  wire [FIdxW-1:0] pm1 = fi - 1'b1;
  wire [FIdxW-1:0] di  = dropi_q[FIdxW-1:0];
  wire [FIdxW-1:0] dn  = di + 1'b1;
  wire [15:0]      carve_rem = fl_q[sel] - size_q;
  wire             absorb = carve_rem < minsl_q;

  always_comb begin
    sts_o = '0;
    sts_o.proc_full   = ucnt_q >= PCntW'(MaxProc);
    sts_o.size_zero   = size_q == 16'd0;
    sts_o.scan_done   = !f_in || (found_q && policy_q != FitBest && policy_q != FitWorst);
    sts_o.found       = found_q;
    sts_o.total_ok    = ftot_q > size_q;
    sts_o.comp_last   = !u_in;
    sts_o.srch_done   = srch_done_q;
    sts_o.srch_hit    = found_q;
    sts_o.pos_done    = pos_done_q;
    sts_o.need_insert = !mp_q && !mn_q;
    sts_o.free_full   = !mp_q && !mn_q && fcnt_q >= FCntW'(MaxFree);
    // A carve that absorbs the whole block must remove it in the same request.
    sts_o.drop_needed = drop_q || (cmd_i.carve && absorb);
    sts_o.fshift_done = fi_q <= sel_q;
    sts_o.used_done   = !(ui_q + 1'b1 < ucnt_q);
    sts_o.drop_done   = !(dropi_q + 1'b1 < fcnt_q);
  end

  assign status_o = st_q;
  assign pid_o    = pid_q;
  assign start_o  = (st_q == StOk) ? start_q : '0;
  assign size_o   = (st_q == StOk) ? got_q : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= FitFirst;
      minsl_q  <= 16'd10;
      fcnt_q   <= FCntW'(1);
      ucnt_q   <= '0;
      ftot_q   <= 16'd1024;
      npid_q   <= '0;
      fs_q[0]  <= '0;
      fl_q[0]  <= 16'd1024;
      drop_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPolicy:   policy_q <= cfg_data_i[1:0];
          CfgMemSize: begin
            ucnt_q  <= '0;
            ftot_q  <= cfg_data_i;
            fs_q[0] <= '0;
            fl_q[0] <= cfg_data_i;
            fcnt_q  <= (cfg_data_i != 16'd0) ? FCntW'(1) : '0;
          end
          CfgMinSlice: minsl_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start_alloc) begin
        npid_q <= npid_q + 16'd1;
        pid_q  <= npid_q + 16'd1;
        size_q <= req_size_i;
        st_q   <= StOk;
        fi_q   <= '0;
        found_q <= 1'b0;
        ui_q   <= '0;
        addr_q <= '0;
        drop_q <= 1'b0;
      end
      if (cmd_i.start_free) begin
        pid_q <= req_pid_i;
        st_q  <= StOk;
        ui_q  <= '0;
        fi_q  <= '0;
        found_q <= 1'b0;
        srch_done_q <= 1'b0;
        pos_done_q <= 1'b0;
        drop_q <= 1'b0;
      end
      if (cmd_i.set_status) st_q <= cmd_i.status;
      if (cmd_i.scan_step) begin
        if (fl_q[fi] >= size_q) begin
          if (!found_q || (policy_q == FitBest && fl_q[fi] < fl_q[sel]) ||
              (policy_q == FitWorst && fl_q[fi] > fl_q[sel])) begin
            sel_q <= fi_q;
          end
          found_q <= 1'b1;
        end
        fi_q <= fi_q + 1'b1;
      end
      if (cmd_i.comp_step) begin
        us_q[ui] <= addr_q;
        addr_q   <= addr_q + ul_q[ui];
        ui_q     <= ui_q + 1'b1;
      end
      if (cmd_i.comp_done) begin
        fcnt_q  <= FCntW'(1);
        fs_q[0] <= addr_q;
        fl_q[0] <= ftot_q;
        sel_q   <= '0;
      end
      if (cmd_i.carve) begin
        start_q <= fs_q[sel];
        if (absorb) begin
          got_q   <= fl_q[sel];
          ftot_q  <= ftot_q - fl_q[sel];
          drop_q  <= 1'b1;
          dropi_q <= sel_q;
          ul_q[ucnt_q[PIdxW-1:0]] <= fl_q[sel];
        end else begin
          got_q    <= size_q;
          ftot_q   <= ftot_q - size_q;
          fs_q[sel] <= fs_q[sel] + size_q;
          fl_q[sel] <= carve_rem;
          ul_q[ucnt_q[PIdxW-1:0]] <= size_q;
        end
        up_q[ucnt_q[PIdxW-1:0]] <= pid_q;
        us_q[ucnt_q[PIdxW-1:0]] <= fs_q[sel];
        ucnt_q <= ucnt_q + 1'b1;
      end
      if (cmd_i.drop_step) begin
        if (dropi_q + 1'b1 < fcnt_q) begin
          fs_q[di] <= fs_q[dn];
          fl_q[di] <= fl_q[dn];
          dropi_q  <= dropi_q + 1'b1;
        end else begin
          fcnt_q <= fcnt_q - 1'b1;
          drop_q <= 1'b0;
        end
      end
      if (cmd_i.srch_step) begin
        if (!u_in) srch_done_q <= 1'b1;
        else if (up_q[ui] == pid_q) begin
          found_q     <= 1'b1;
          srch_done_q <= 1'b1;
          start_q     <= us_q[ui];
          got_q       <= ul_q[ui];
        end else ui_q <= ui_q + 1'b1;
      end
      if (cmd_i.pos_step) begin
        if (f_in && fs_q[fi] <= start_q) fi_q <= fi_q + 1'b1;
        else begin
          pos_done_q <= 1'b1;
          mp_q <= (fi_q != '0) && (fs_q[pm1] + fl_q[pm1] == start_q);
          mn_q <= f_in && (start_q + got_q == fs_q[fi]);
        end
      end
      if (cmd_i.merge) begin
        ftot_q <= ftot_q + got_q;
        if (mp_q && mn_q) begin
          fl_q[pm1] <= fl_q[pm1] + got_q + fl_q[fi];
          drop_q  <= 1'b1;
          dropi_q <= fi_q;
        end else if (mp_q) fl_q[pm1] <= fl_q[pm1] + got_q;
        else if (mn_q) begin
          fs_q[fi] <= start_q;
          fl_q[fi] <= fl_q[fi] + got_q;
        end else begin
          // Insert position kept in sel, shift cursor runs from the top down.
          sel_q <= fi_q;
          fi_q  <= fcnt_q;
        end
      end
      if (cmd_i.fshift_step) begin
        if (fi_q > sel_q) begin
          fs_q[fi] <= fs_q[fi - 1'b1];
          fl_q[fi] <= fl_q[fi - 1'b1];
          fi_q     <= fi_q - 1'b1;
        end else begin
          fs_q[sel] <= start_q;
          fl_q[sel] <= got_q;
          fcnt_q    <= fcnt_q + 1'b1;
        end
      end
      if (cmd_i.used_step) begin
        if (ui_q + 1'b1 < ucnt_q) begin
          up_q[ui] <= up_q[ui + 1'b1];
          us_q[ui] <= us_q[ui + 1'b1];
          ul_q[ui] <= ul_q[ui + 1'b1];
          ui_q     <= ui_q + 1'b1;
        end else ucnt_q <= ucnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/variable_partition_allocator_top.sv -----
// Top level of the variable partition allocator.
// Depends on vpa_pkg, vpa_ctrl and vpa_dp.
//
//  channel  | handshake               | payload
//  request  | in_valid_i / in_ready_o | opcode_i, request_size_i, process_id_i
//  result   | out_valid_o/out_ready_i | status_o, assigned_pid_o, grant_start_o, grant_size_o
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time; the time until the result is valid is set by the free table scan,
// the compaction walk over the allocations and the one-entry-a-cycle table shifts.
// Reset gives one free block of 1024 units; no clearing pass is needed.
// A new request is taken once the previous result has been taken.
module variable_partition_allocator_top import vpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] process_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] assigned_pid_o,
  output logic [15:0] grant_start_o,
  output logic [15:0] grant_size_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  vpa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(in_valid_i), .req_op_i(opcode_i), .req_ready_o(in_ready_o),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i),
    .sts_i(sts), .cmd_o(cmd)
  );

  vpa_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .req_size_i(request_size_i), .req_pid_i(process_id_i),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(status_o), .pid_o(assigned_pid_o),
    .start_o(grant_start_o), .size_o(grant_size_o)
  );

endmodule

// ----- sv/vpa_checker.sv -----
// Port-level checks for the allocator top level, with the bind that attaches them.
// Depends on vpa_pkg and variable_partition_allocator_top.
module vpa_checker import vpa_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [15:0] grant_size_o,
  input logic [15:0] grant_start_o
);

  // Never take a new request while a result waits.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken while result pending");

  // A result cannot appear in the cycle right after a request.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");

  // Failed requests report an empty region.
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (grant_size_o == 16'd0 && grant_start_o == 16'd0))
    else $error("failed request with nonzero region");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)))
    else $error("result dropped while stalled");

endmodule

bind variable_partition_allocator_top vpa_checker u_vpa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .grant_size_o, .grant_start_o
);
